// ===== hdl/hstd_pkg.sv =====
// ----------------------------------------------------------------------------
// hstd_pkg
// Shared widths, register indexes, mode codes and the multiply/accumulate
// control word of the stereo multi-tap delay.
// ----------------------------------------------------------------------------
package hstd_pkg;

    localparam int LINE_DEPTH_DEF = 16384;
    localparam int GAIN_FRAC_DEF  = 12;

    localparam int SAMPLE_W   = 16;
    localparam int MONO_W     = 17;
    localparam int GAIN_W     = 16;
    localparam int SKEW_W     = 11;
    localparam int DELAY_W    = 14;
    localparam int DLY_CALC_W = 17;   // holds base delay plus skew and line depths up to 131072
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 51;
    localparam int ACC_W      = 54;
    localparam int NUM_TAPS   = 5;
    localparam int TAP_IDX_W  = 3;
    localparam int STEP_W     = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAINS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAINS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAINS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_SKEW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_DELAY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_SKEW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LATE_DELAY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_MODE   = 3'd7;

    // channel modes; the unused code behaves as normal
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SWAP   = 2'd1;
    localparam logic [1:0] MODE_MONO   = 2'd2;

    // what the accumulator does with the registered product
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_TAP  = 2'd1;
    localparam logic [1:0] ACC_DRY  = 2'd2;

    localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

    typedef struct packed {
        logic       clr;      // clear both accumulators
        logic       mul_en;   // load the product register
        logic       a_prod;   // multiplier A from previous product
        logic [1:0] kind;     // ACC_* for this product
        logic       side;     // 0 left accumulator, 1 right
    } hstd_mac_ctrl_t;

endpackage

// ===== hdl/haas_stereo_multitap_delay.sv =====
// ----------------------------------------------------------------------------
// haas_stereo_multitap_delay
// Stereo multi-tap delay for Haas-effect placement: mono sum into a delay
// line, five taps, dry/wet mix per side, normal/swapped/mono output.
// ----------------------------------------------------------------------------
// One sample pair at a time: after a transfer on s_ the block is busy until
// the result appears on m_, the same clock at which s_ is ready again, so a
// new pair is taken only once the last one has left the sequencer. A result
// still waiting on m_ holds the next pair in its last step until it leaves.
// The busy time comes from the five tap reads through the single read port
// of the delay line and the 14 products through the one shared multiplier
// (wet*gain, then times the tap, three taps per side, plus the dry term per
// side), with the DRAIN state to accumulate and the OUT state to load the
// output register. The delay line needs no clearing pass after reset: slots
// not yet written read as zero. Configuration may be written whenever no
// sample is in flight; tap delays beyond the line are clamped to its last slot.
// ----------------------------------------------------------------------------
module haas_stereo_multitap_delay #(
    parameter int LINE_DEPTH     = hstd_pkg::LINE_DEPTH_DEF,
    parameter int GAIN_FRAC_BITS = hstd_pkg::GAIN_FRAC_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,    // [15:0] left_in, [31:16] right_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,    // [15:0] left_out, [31:16] right_out
    input  logic                               cfg_we,
    input  logic [hstd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [hstd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int DCW = hstd_pkg::DLY_CALC_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [hstd_pkg::STEP_W-1:0] LAST_READ = 3'd5;
    localparam logic [hstd_pkg::STEP_W-1:0] DRY_STEP  = 3'd6;

    // configuration
    logic [31:0]                          mix_reg;
    logic [47:0]                          lgain_reg;
    logic [47:0]                          rgain_reg;
    logic [hstd_pkg::SKEW_W-1:0]          dskew_reg;
    logic [hstd_pkg::DELAY_W-1:0]         edly_reg;
    logic [hstd_pkg::SKEW_W-1:0]          eskew_reg;
    logic [hstd_pkg::DELAY_W-1:0]         ldly_reg;
    logic [1:0]                           mode_reg;

    // sequencer and payload
    logic [2:0]                           state_reg;
    logic [2:0]                           state_next;
    logic [hstd_pkg::STEP_W-1:0]          step_reg;
    logic                                 side_reg;
    logic                                 m_valid_reg;
    logic [31:0]                          m_data_reg;
    logic [hstd_pkg::SAMPLE_W-1:0]        in_l_reg;
    logic [hstd_pkg::SAMPLE_W-1:0]        in_r_reg;
    logic signed [hstd_pkg::MONO_W-1:0]   tap_reg [hstd_pkg::NUM_TAPS];

    logic                                 accept;
    logic                                 out_free;
    logic signed [hstd_pkg::MONO_W-1:0]   mono_in;
    logic signed [hstd_pkg::MONO_W-1:0]   rd_data;
    logic [AW-1:0]                        rd_delay;
    logic                                 rd_en;
    logic [hstd_pkg::TAP_IDX_W-1:0]       cap_idx;

    // delay arithmetic
    logic [hstd_pkg::SKEW_W-1:0]          ds_abs;
    logic [hstd_pkg::SKEW_W-1:0]          es_abs;
    logic [DCW-1:0]                       e_base;
    logic [DCW-1:0]                       e_long;
    logic [DCW-1:0]                       lmax;
    logic [AW-1:0]                        d_l;
    logic [AW-1:0]                        d_r;
    logic [AW-1:0]                        e_l;
    logic [AW-1:0]                        e_r;
    logic [AW-1:0]                        d_late;

    // multiply step decode
    hstd_pkg::hstd_mac_ctrl_t             mac_ctrl;
    logic                                 gsel;
    logic [1:0]                           term_idx;
    logic [47:0]                          gset;
    logic [hstd_pkg::GAIN_W-1:0]          op_a;
    logic signed [hstd_pkg::MUL_B_W-1:0]  op_b;
    logic [hstd_pkg::TAP_IDX_W-1:0]       tap_sel;
    logic signed [hstd_pkg::MONO_W-1:0]   tap_val;
    logic [hstd_pkg::SAMPLE_W-1:0]        in_side;
    logic [hstd_pkg::SAMPLE_W-1:0]        out_l;
    logic [hstd_pkg::SAMPLE_W-1:0]        out_r;

    function automatic logic [AW-1:0] clamp_dly(input logic [DCW-1:0] d);
        if (d > DCW'(LINE_DEPTH - 1)) begin
            return AW'(LINE_DEPTH - 1);
        end
        return d[AW-1:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign mono_in = $signed({s_tdata[15], s_tdata[15:0]})
                   + $signed({s_tdata[31], s_tdata[31:16]});

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_reg   <= 32'h1000_0000;
            lgain_reg <= 48'h1000;
            rgain_reg <= 48'h1000;
            dskew_reg <= '0;
            edly_reg  <= '0;
            eskew_reg <= '0;
            ldly_reg  <= '0;
            mode_reg  <= hstd_pkg::MODE_NORMAL;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                hstd_pkg::REG_MIX_GAINS:   mix_reg   <= cfg_wdata[31:0];
                hstd_pkg::REG_LEFT_GAINS:  lgain_reg <= cfg_wdata;
                hstd_pkg::REG_RIGHT_GAINS: rgain_reg <= cfg_wdata;
                hstd_pkg::REG_DIRECT_SKEW: dskew_reg <= cfg_wdata[hstd_pkg::SKEW_W-1:0];
                hstd_pkg::REG_EARLY_DELAY: edly_reg  <= cfg_wdata[hstd_pkg::DELAY_W-1:0];
                hstd_pkg::REG_EARLY_SKEW:  eskew_reg <= cfg_wdata[hstd_pkg::SKEW_W-1:0];
                hstd_pkg::REG_LATE_DELAY:  ldly_reg  <= cfg_wdata[hstd_pkg::DELAY_W-1:0];
                hstd_pkg::REG_CHAN_MODE:   mode_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // ---------------- tap delays ----------------
    always_comb begin
        // magnitude; -1024 comes out as 1024 in 11 unsigned bits
        ds_abs = dskew_reg[hstd_pkg::SKEW_W-1] ? (~dskew_reg + 1'b1) : dskew_reg;
        es_abs = eskew_reg[hstd_pkg::SKEW_W-1] ? (~eskew_reg + 1'b1) : eskew_reg;
        e_base = DCW'(edly_reg);
        e_long = e_base + DCW'(es_abs);
        lmax   = DCW'(ds_abs);
        if (e_long > lmax) begin
            lmax = e_long;
        end
        if (DCW'(ldly_reg) > lmax) begin
            lmax = DCW'(ldly_reg);
        end
        d_l    = dskew_reg[hstd_pkg::SKEW_W-1] ? '0 : clamp_dly(DCW'(ds_abs));
        d_r    = dskew_reg[hstd_pkg::SKEW_W-1] ? clamp_dly(DCW'(ds_abs)) : '0;
        e_l    = clamp_dly(eskew_reg[hstd_pkg::SKEW_W-1] ? e_base : e_long);
        e_r    = clamp_dly(eskew_reg[hstd_pkg::SKEW_W-1] ? e_long : e_base);
        d_late = clamp_dly(lmax);
    end

    // read order: direct L, direct R, early L, early R, late
    always_comb begin
        case (step_reg)
            3'd0:    rd_delay = d_l;
            3'd1:    rd_delay = d_r;
            3'd2:    rd_delay = e_l;
            3'd3:    rd_delay = e_r;
            default: rd_delay = d_late;
        endcase
    end

    assign rd_en   = (state_reg == ST_READ) && (step_reg != LAST_READ);
    assign cap_idx = step_reg - 1'b1;

    hstd_line #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (accept),
        .wr_data  (mono_in),
        .advance  (state_reg == ST_DRAIN),
        .rd_en    (rd_en),
        .rd_delay (rd_delay),
        .rd_data  (rd_data)
    );

    // ---------------- multiply steps ----------------
    // per output side: even steps wet*gain, odd steps times the tap, step 6 dry*in
    always_comb begin
        gsel     = side_reg ^ (mode_reg == hstd_pkg::MODE_SWAP);
        term_idx = step_reg[2:1];
        gset     = gsel ? rgain_reg : lgain_reg;
        tap_sel  = (term_idx == 2'd2) ? 3'd4 : {1'b0, term_idx[0], gsel};
        tap_val  = tap_reg[tap_sel];
        in_side  = side_reg ? in_r_reg : in_l_reg;

        case (term_idx)
            2'd0:    op_a = gset[15:0];
            2'd1:    op_a = gset[31:16];
            2'd2:    op_a = gset[47:32];
            default: op_a = mix_reg[15:0];
        endcase

        if (step_reg == DRY_STEP) begin
            op_b = $signed({{2{in_side[15]}}, in_side});
        end else if (step_reg[0]) begin
            op_b = $signed({tap_val[hstd_pkg::MONO_W-1], tap_val});
        end else begin
            op_b = $signed({2'b00, mix_reg[31:16]});
        end

        mac_ctrl.clr    = accept;
        mac_ctrl.mul_en = (state_reg == ST_MUL);
        mac_ctrl.a_prod = step_reg[0];
        mac_ctrl.side   = side_reg;
        if (step_reg == DRY_STEP) begin
            mac_ctrl.kind = hstd_pkg::ACC_DRY;
        end else if (step_reg[0]) begin
            mac_ctrl.kind = hstd_pkg::ACC_TAP;
        end else begin
            mac_ctrl.kind = hstd_pkg::ACC_NONE;
        end
    end

    hstd_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .mono    (mode_reg == hstd_pkg::MODE_MONO),
        .out_l   (out_l),
        .out_r   (out_r)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_READ;
            ST_READ:  if (step_reg == LAST_READ) state_next = ST_MUL;
            ST_MUL:   if (side_reg && step_reg == DRY_STEP) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            side_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_READ: begin
                    step_reg <= (step_reg == LAST_READ) ? '0 : step_reg + 1'b1;
                end
                ST_MUL: begin
                    if (step_reg == DRY_STEP) begin
                        step_reg <= '0;
                        side_reg <= ~side_reg;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                default: begin
                    step_reg <= '0;
                    side_reg <= 1'b0;
                end
            endcase
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_l_reg <= s_tdata[15:0];
            in_r_reg <= s_tdata[31:16];
        end
        // read data lands in the cycle after its address
        if (state_reg == ST_READ && step_reg != '0) begin
            tap_reg[cap_idx] <= rd_data;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= {out_r, out_l};
        end
    end

endmodule

// ===== hdl/hstd_line.sv =====
// ----------------------------------------------------------------------------
// hstd_line
// Circular delay line of mono sums: one write and one registered read per
// cycle. Entries not yet written since reset read back as zero.
// ----------------------------------------------------------------------------
module hstd_line #(
    parameter int LINE_DEPTH = hstd_pkg::LINE_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   wr_en,
    input  logic signed [hstd_pkg::MONO_W-1:0]     wr_data,
    input  logic                                   advance,
    input  logic                                   rd_en,
    input  logic [$clog2(LINE_DEPTH)-1:0]          rd_delay,
    output logic signed [hstd_pkg::MONO_W-1:0]     rd_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    logic [hstd_pkg::MONO_W-1:0] line_reg [LINE_DEPTH];
    logic [hstd_pkg::MONO_W-1:0] rd_q_reg;
    logic                        rd_ok_reg;
    logic [AW-1:0]               wi_reg;
    logic                        wrapped_reg;
    logic [AW:0]                 addr_wide;
    logic [AW-1:0]               rd_addr;
    logic                        rd_ok;

    // wi - d modulo depth, delay never exceeds depth - 1
    always_comb begin
        if (wi_reg >= rd_delay) begin
            addr_wide = (AW+1)'(wi_reg) - (AW+1)'(rd_delay);
        end else begin
            addr_wide = (AW+1)'(wi_reg) + (AW+1)'(LINE_DEPTH) - (AW+1)'(rd_delay);
        end
        rd_addr = addr_wide[AW-1:0];
        // fill tracking: before the first wrap only 0..wi hold data
        rd_ok   = wrapped_reg || (rd_addr <= wi_reg);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_reg[wi_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= line_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg      <= '0;
            wrapped_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_ok_reg <= rd_ok;
            end
            if (advance) begin
                if (wi_reg == AW'(LINE_DEPTH - 1)) begin
                    wi_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wi_reg <= wi_reg + 1'b1;
                end
            end
        end
    end

    assign rd_data = rd_ok_reg ? $signed(rd_q_reg) : '0;

endmodule

// ===== hdl/hstd_mac.sv =====
// ----------------------------------------------------------------------------
// hstd_mac
// Shared 33x18 multiplier with a product register, two accumulators and the
// output scaling / saturation.
// ----------------------------------------------------------------------------
module hstd_mac #(
    parameter int GAIN_FRAC_BITS = hstd_pkg::GAIN_FRAC_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  hstd_pkg::hstd_mac_ctrl_t               ctrl,
    input  logic [hstd_pkg::GAIN_W-1:0]            op_a,
    input  logic signed [hstd_pkg::MUL_B_W-1:0]    op_b,
    input  logic                                   mono,
    output logic [hstd_pkg::SAMPLE_W-1:0]          out_l,
    output logic [hstd_pkg::SAMPLE_W-1:0]          out_r
);

    localparam int ACC_W = hstd_pkg::ACC_W;
    localparam int SHIFT = 2 * GAIN_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

    logic signed [hstd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [hstd_pkg::PROD_W-1:0]  mul_p;
    logic signed [hstd_pkg::PROD_W-1:0]  prod_reg;
    logic [1:0]                          kind_reg;
    logic                                side_reg;
    logic signed [ACC_W-1:0]             acc_l_reg;
    logic signed [ACC_W-1:0]             acc_r_reg;
    logic signed [ACC_W-1:0]             term;
    logic signed [ACC_W-1:0]             mono_sum;
    logic signed [ACC_W-1:0]             full_l;
    logic signed [ACC_W-1:0]             full_r;

    function automatic logic [hstd_pkg::SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = v >>> SHIFT;   // floor toward minus infinity
        if (q > Q_MAX) begin
            return hstd_pkg::SAT_MAX;
        end else if (q < Q_MIN) begin
            return hstd_pkg::SAT_MIN;
        end
        return q[hstd_pkg::SAMPLE_W-1:0];
    endfunction

    // A is either a 16-bit gain or the wet*gain product held from last cycle
    assign mul_a = ctrl.a_prod ? $signed({1'b0, prod_reg[31:0]})
                               : $signed({17'd0, op_a});
    assign mul_p = mul_a * op_b;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= mul_p;
        end
    end

    always_comb begin
        if (kind_reg == hstd_pkg::ACC_DRY) begin
            term = ACC_W'(prod_reg) <<< GAIN_FRAC_BITS;
        end else begin
            term = ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= hstd_pkg::ACC_NONE;
            side_reg  <= 1'b0;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else begin
            kind_reg <= ctrl.mul_en ? ctrl.kind : hstd_pkg::ACC_NONE;
            side_reg <= ctrl.side;
            if (ctrl.clr) begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end else if (kind_reg != hstd_pkg::ACC_NONE) begin
                if (side_reg) begin
                    acc_r_reg <= acc_r_reg + term;
                end else begin
                    acc_l_reg <= acc_l_reg + term;
                end
            end
        end
    end

    assign mono_sum = acc_l_reg + acc_r_reg;
    assign full_l   = mono ? mono_sum : acc_l_reg;
    assign full_r   = mono ? mono_sum : acc_r_reg;
    assign out_l    = sat16(full_l);
    assign out_r    = sat16(full_r);

endmodule
